[hw/rtl/emst_pkg.sv]
// Shared types and constants for the extent map sector translator.
`default_nettype none

package emst_pkg;

   localparam int MAX_EXTENTS_DEFAULT = 64;
   localparam int SECTOR_WIDTH = 64;
   localparam int COUNT_WIDTH = 7;
   localparam int INDEX_WIDTH = 6;

   localparam logic ACT_WRITE = 1'b0;
   localparam logic ACT_TRANSLATE = 1'b1;

   typedef struct packed {
      logic                    action;
      logic [INDEX_WIDTH-1:0]  entry_index;
      logic [SECTOR_WIDTH-1:0] extent_start;
      logic [SECTOR_WIDTH-1:0] extent_end;
      logic [SECTOR_WIDTH-1:0] logical_sector;
   } req_item_type;

   typedef struct packed {
      logic                    found;
      logic [SECTOR_WIDTH-1:0] physical_sector;
      logic [SECTOR_WIDTH-1:0] run_remaining;
   } rsp_item_type;

   typedef struct packed {
      logic [SECTOR_WIDTH-1:0] sector_first;
      logic [SECTOR_WIDTH-1:0] sector_stop;
   } entry_type;

endpackage

`default_nettype wire

[hw/rtl/extent_map_sector_translate.sv]
// Top level of the extent map sector translator: table RAM, walk pipeline, result register.
`default_nettype none

// A write item stores one extent in the table in the cycle it is accepted and
// gives no result; busy stays low. A translate item walks the table from entry
// 0, reading one entry per cycle through the single RAM read port, and keeps
// busy high until it decides: on a match at entry k, or on a miss once
// min(extent_count, MAX_EXTENTS) entries are read. An extent_count of zero
// answers without walking the table and with busy never raised. The result is
// shown for exactly one cycle with rsp_strobe, in the first cycle that busy is
// low again; the receiver cannot hold it off, so it must take it then. Table
// entries are undefined until written and a translate must only reach written
// entries. Write the count register only while no translate is in progress.
module extent_map_sector_translate #(
   parameter int MAX_EXTENTS = emst_pkg::MAX_EXTENTS_DEFAULT
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    start,
   output logic                         busy,
   input  wire emst_pkg::req_item_type  req_item,
   output logic                         rsp_strobe,
   output emst_pkg::rsp_item_type       rsp_item,
   input  wire logic                    csr_valid,
   output logic                         csr_ready,
   input  wire logic [emst_pkg::COUNT_WIDTH-1:0] csr_data
);

   localparam int AW = (MAX_EXTENTS > 1) ? $clog2(MAX_EXTENTS) : 1;
   localparam int SW = emst_pkg::SECTOR_WIDTH;
   localparam int CW = emst_pkg::COUNT_WIDTH;
   localparam int EW = 2 * SW;

   localparam logic ST_IDLE = 1'b0;
   localparam logic ST_WALK = 1'b1;

   logic state_ff, state_in;
   logic [CW-1:0] count_ff, count_in;
   logic [CW-1:0] limit_ff, limit_in;
   logic [CW-1:0] issue_k_ff, issue_k_in;
   logic v1_ff, v1_in, last1_ff, last1_in;
   logic v2_ff, v2_in, last2_ff, last2_in;
   logic [SW-1:0] len_ff, len_in;
   logic [SW-1:0] first_ff, first_in;
   logic [SW-1:0] off_ff, off_in;
   logic rsp_strobe_ff, rsp_strobe_in;
   emst_pkg::rsp_item_type rsp_item_ff, rsp_item_in;

   logic accept, wr_en, rd_en, issue_last, hit;
   logic [CW-1:0] limit_sel;
   emst_pkg::entry_type wr_entry, rd_entry;
   logic [EW-1:0] rd_data;

   assign accept = start && !busy;
   assign busy = (state_ff == ST_WALK);
   assign csr_ready = !busy;
   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_item = rsp_item_ff;

   assign wr_en = accept && (req_item.action == emst_pkg::ACT_WRITE)
                  && (32'(req_item.entry_index) < MAX_EXTENTS);
   assign wr_entry.sector_first = req_item.extent_start;
   assign wr_entry.sector_stop = req_item.extent_end;

   assign rd_en = (state_ff == ST_WALK) && (issue_k_ff < limit_ff);
   assign issue_last = (issue_k_ff == limit_ff - CW'(1));
   assign rd_entry = rd_data;
   assign hit = off_ff < len_ff;

   assign limit_sel = (32'(count_ff) > MAX_EXTENTS) ? CW'(MAX_EXTENTS) : count_ff;

   emst_ram #(
      .WIDTH (EW),
      .DEPTH (MAX_EXTENTS)
   ) u_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (AW'(req_item.entry_index)),
      .wr_data (wr_entry),
      .rd_en   (rd_en),
      .rd_addr (AW'(issue_k_ff)),
      .rd_data (rd_data)
   );

   always_comb begin
      state_in = state_ff;
      count_in = count_ff;
      limit_in = limit_ff;
      issue_k_in = issue_k_ff;
      off_in = off_ff;
      v1_in = rd_en;
      last1_in = issue_last;
      v2_in = v1_ff;
      last2_in = last1_ff;
      len_in = rd_entry.sector_stop - rd_entry.sector_first;
      first_in = rd_entry.sector_first;
      rsp_strobe_in = 1'b0;
      rsp_item_in = rsp_item_ff;

      if (csr_valid && csr_ready) begin
         count_in = csr_data;
      end

      if (rd_en) begin
         issue_k_in = issue_k_ff + CW'(1);
      end

      if (accept && (req_item.action == emst_pkg::ACT_TRANSLATE)) begin
         limit_in = limit_sel;
         issue_k_in = '0;
         off_in = req_item.logical_sector;
         if (limit_sel == '0) begin
            rsp_strobe_in = 1'b1;
            rsp_item_in = '0;
         end else begin
            state_in = ST_WALK;
         end
      end

      if (v2_ff) begin
         if (hit) begin
            rsp_strobe_in = 1'b1;
            rsp_item_in.found = 1'b1;
            rsp_item_in.physical_sector = first_ff + off_ff;
            rsp_item_in.run_remaining = len_ff - off_ff;
            state_in = ST_IDLE;
            v1_in = 1'b0;
            v2_in = 1'b0;
         end else if (last2_ff) begin
            rsp_strobe_in = 1'b1;
            rsp_item_in = '0;
            state_in = ST_IDLE;
            v1_in = 1'b0;
            v2_in = 1'b0;
         end else begin
            off_in = off_ff - len_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         count_ff <= '0;
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         v1_ff <= v1_in;
         v2_ff <= v2_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      limit_ff <= limit_in;
      issue_k_ff <= issue_k_in;
      last1_ff <= last1_in;
      last2_ff <= last2_in;
      len_ff <= len_in;
      first_ff <= first_in;
      off_ff <= off_in;
      rsp_item_ff <= rsp_item_in;
   end

   a_idle_quiet: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE) |-> !(v1_ff || v2_ff || rd_en))
      else $error("walk pipeline active while idle");

   a_strobe_cause: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(busy || (start && req_item.action == emst_pkg::ACT_TRANSLATE)))
      else $error("result without a translate item");

   a_found_run: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_item.found) |-> (rsp_item.run_remaining != '0))
      else $error("found result with empty run");

   a_issue_bound: assert property (@(posedge clock) disable iff (reset)
      rd_en |-> (32'(issue_k_ff) < MAX_EXTENTS))
      else $error("table read beyond table size");

endmodule

`default_nettype wire

[hw/rtl/emst_ram.sv]
// Generic single-write, single-read synchronous RAM with registered read data.
`default_nettype none

module emst_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic             clock,
   input  wire logic             wr_en,
   input  wire logic [AW-1:0]    wr_addr,
   input  wire logic [WIDTH-1:0] wr_data,
   input  wire logic             rd_en,
   input  wire logic [AW-1:0]    rd_addr,
   output logic      [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

`default_nettype wire

[tb/sv/extent_translate_check_pkg.sv]
// Scoreboard class that predicts and checks extent map translate results.
package extent_translate_check_pkg;

   localparam int TABLE_DEPTH = emst_pkg::MAX_EXTENTS_DEFAULT;

   class extent_translate_tracker;

      logic [emst_pkg::SECTOR_WIDTH-1:0] extent_starts [TABLE_DEPTH];
      logic [emst_pkg::SECTOR_WIDTH-1:0] extent_ends [TABLE_DEPTH];
      logic [emst_pkg::COUNT_WIDTH-1:0]  extent_count;
      emst_pkg::rsp_item_type            pending_answers [$];
      int                                errors;

      function new();
         extent_count = '0;
         errors = 0;
      endfunction

      function void set_count(input logic [emst_pkg::COUNT_WIDTH-1:0] value);
         extent_count = value;
      endfunction

      function emst_pkg::rsp_item_type map_logical_sector(
         input logic [emst_pkg::SECTOR_WIDTH-1:0] lsec);
         emst_pkg::rsp_item_type            answer;
         logic [emst_pkg::SECTOR_WIDTH-1:0] base;
         logic [emst_pkg::SECTOR_WIDTH-1:0] span;
         logic [emst_pkg::SECTOR_WIDTH-1:0] offset;
         int                                walk_limit;
         int                                k;
         answer = '0;
         base = '0;
         walk_limit = (extent_count > TABLE_DEPTH) ? TABLE_DEPTH : int'(extent_count);
         for (k = 0; k < walk_limit; k++) begin
            span = extent_ends[k] - extent_starts[k];
            offset = lsec - base;
            if (offset < span) begin
               answer.found = 1'b1;
               answer.physical_sector = extent_starts[k] + offset;
               answer.run_remaining = span - offset;
               return answer;
            end
            base = base + span;
         end
         return answer;
      endfunction

      function void note_request(input emst_pkg::req_item_type item);
         if (item.action == emst_pkg::ACT_WRITE) begin
            if (item.entry_index < TABLE_DEPTH) begin
               extent_starts[item.entry_index] = item.extent_start;
               extent_ends[item.entry_index] = item.extent_end;
            end
         end else begin
            pending_answers.push_back(map_logical_sector(item.logical_sector));
         end
      endfunction

      function void check_answer(input emst_pkg::rsp_item_type got);
         emst_pkg::rsp_item_type want;
         if (pending_answers.size() == 0) begin
            $display("%0t: result with none expected: found=%b phys=%h remaining=%h",
                     $time, got.found, got.physical_sector, got.run_remaining);
            errors++;
            return;
         end
         want = pending_answers.pop_front();
         if (got.found !== want.found) begin
            $display("%0t: found expected %b actual %b", $time, want.found, got.found);
            errors++;
         end
         if (got.physical_sector !== want.physical_sector) begin
            $display("%0t: physical_sector expected %h actual %h",
                     $time, want.physical_sector, got.physical_sector);
            errors++;
         end
         if (got.run_remaining !== want.run_remaining) begin
            $display("%0t: run_remaining expected %h actual %h",
                     $time, want.run_remaining, got.run_remaining);
            errors++;
         end
      endfunction

   endclass

endpackage

[tb/sv/tb_extent_map_sector_translate.sv]
// Testbench for the extent map sector translator: directed and random items against a scoreboard.
module tb_extent_map_sector_translate;

   localparam int TABLE_DEPTH = extent_translate_check_pkg::TABLE_DEPTH;
   localparam int SECTOR_WIDTH = emst_pkg::SECTOR_WIDTH;
   localparam int COUNT_WIDTH = emst_pkg::COUNT_WIDTH;
   localparam int INDEX_WIDTH = emst_pkg::INDEX_WIDTH;
   localparam int ITEM_TARGET = 1800;
   localparam int DRAIN_CYCLES = TABLE_DEPTH + 8;
   localparam int CYCLE_LIMIT = 1_500_000;
   localparam logic [SECTOR_WIDTH-1:0] ALL_ONES = '1;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   start = 1'b0;
   logic                   busy;
   emst_pkg::req_item_type req_item = '0;
   logic                   rsp_strobe;
   emst_pkg::rsp_item_type rsp_item;
   logic                   csr_valid = 1'b0;
   logic                   csr_ready;
   logic [COUNT_WIDTH-1:0] csr_data = '0;

   extent_translate_check_pkg::extent_translate_tracker tracker = new();
   int                      sent = 0;
   int unsigned             cycle_count = 0;

   extent_map_sector_translate uut (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .req_item(req_item),
      .rsp_strobe(rsp_strobe),
      .rsp_item(rsp_item),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_data(csr_data)
   );

   always #2 clock = ~clock;

   always @(posedge clock) begin
      if (reset === 1'b0 && rsp_strobe !== 1'b0)
         tracker.check_answer(rsp_item);
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("FAIL extent_map_sector_translate");
         $finish;
      end
   end

   function automatic logic [SECTOR_WIDTH-1:0] rand64();
      return {$urandom, $urandom};
   endfunction

   function automatic emst_pkg::req_item_type write_item(input int idx,
                                                         input emst_pkg::entry_type e);
      emst_pkg::req_item_type item;
      item.action = emst_pkg::ACT_WRITE;
      item.entry_index = idx[INDEX_WIDTH-1:0];
      item.extent_start = e.sector_first;
      item.extent_end = e.sector_stop;
      item.logical_sector = rand64();
      return item;
   endfunction

   function automatic emst_pkg::req_item_type translate_item(
      input logic [SECTOR_WIDTH-1:0] lsec);
      emst_pkg::req_item_type item;
      item.action = emst_pkg::ACT_TRANSLATE;
      item.entry_index = INDEX_WIDTH'($urandom_range(0, TABLE_DEPTH - 1));
      item.extent_start = rand64();
      item.extent_end = rand64();
      item.logical_sector = lsec;
      return item;
   endfunction

   function automatic emst_pkg::entry_type make_extent(input logic [SECTOR_WIDTH-1:0] first,
                                                       input logic [SECTOR_WIDTH-1:0] stop);
      emst_pkg::entry_type e;
      e.sector_first = first;
      e.sector_stop = stop;
      return e;
   endfunction

   function automatic emst_pkg::entry_type random_extent(input bit tame);
      logic [SECTOR_WIDTH-1:0] first;
      int                      sel;
      first = $urandom_range(0, 1) ? rand64() : {32'd0, $urandom};
      sel = tame ? $urandom_range(0, 5) : $urandom_range(0, 9);
      case (sel)
         0: return make_extent(first, first);
         1: return make_extent(first, first + 1);
         2, 3, 4, 5: return make_extent(first, first + $urandom_range(1, 4096));
         6: return make_extent(first, first - $urandom_range(1, 1000));
         default: return make_extent(first, rand64());
      endcase
   endfunction

   function automatic logic [SECTOR_WIDTH-1:0] pick_sector();
      logic [SECTOR_WIDTH-1:0] base;
      logic [SECTOR_WIDTH-1:0] span;
      int                      walk_limit;
      int                      k;
      int                      i;
      int                      sel;
      walk_limit = (tracker.extent_count > TABLE_DEPTH) ? TABLE_DEPTH
                                                         : int'(tracker.extent_count);
      sel = $urandom_range(0, 99);
      if (walk_limit == 0 || sel < 12)
         return rand64();
      k = (sel < 24) ? walk_limit : $urandom_range(0, walk_limit - 1);
      base = '0;
      for (i = 0; i < k; i++)
         base = base + (tracker.extent_ends[i] - tracker.extent_starts[i]);
      if (k == walk_limit)
         return base + $urandom_range(0, 3);
      span = tracker.extent_ends[k] - tracker.extent_starts[k];
      case ($urandom_range(0, 3))
         0: return base;
         1: return base + span - 1;
         2: return base + ((span == 0) ? '0 : rand64() % span);
         default: return base + $urandom_range(0, 7);
      endcase
   endfunction

   task automatic issue(input emst_pkg::req_item_type item);
      req_item <= item;
      start <= 1'b1;
      @(posedge clock);
      while (busy !== 1'b0) @(posedge clock);
      tracker.note_request(item);
      sent++;
   endtask

   task automatic sender_gap(input bit burst);
      int sel;
      int gap;
      sel = $urandom_range(0, 99);
      if (burst || sel < 55)
         gap = 0;
      else if (sel < 85)
         gap = $urandom_range(1, 3);
      else if (sel < 97)
         gap = $urandom_range(4, 12);
      else
         gap = $urandom_range(20, 60);
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic settle();
      start <= 1'b0;
      while (tracker.pending_answers.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_count(input logic [COUNT_WIDTH-1:0] value);
      csr_data <= value;
      csr_valid <= 1'b1;
      @(posedge clock);
      while (csr_ready !== 1'b1) @(posedge clock);
      csr_valid <= 1'b0;
      tracker.set_count(value);
   endtask

   initial begin
      int  phase;
      int  fill_count;
      int  translate_count;
      int  i;
      bit  burst;
      bit  tame;
      logic [COUNT_WIDTH-1:0] count_value;

      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      write_count('0);
      issue(translate_item('0));
      issue(translate_item(ALL_ONES));
      issue(write_item(0, make_extent(64'd100, 64'd110)));
      issue(write_item(1, make_extent(64'd5, 64'd5)));
      issue(write_item(2, make_extent(64'd20, 64'd10)));
      issue(write_item(3, make_extent(ALL_ONES, ALL_ONES)));
      issue(write_item(TABLE_DEPTH - 1, make_extent(ALL_ONES, '0)));
      settle();
      write_count(7'd1);
      issue(translate_item(64'd0));
      issue(translate_item(64'd9));
      issue(translate_item(64'd10));
      settle();
      write_count(7'd4);
      issue(translate_item(64'd10));
      issue(translate_item(ALL_ONES));
      issue(translate_item(64'd5));
      issue(translate_item(64'd0));

      phase = 0;
      while (sent < ITEM_TARGET) begin
         settle();
         burst = ($urandom_range(0, 3) == 0);
         tame = 1'($urandom_range(0, 1));
         case ($urandom_range(0, 9))
            0: count_value = '0;
            1: count_value = 7'd1;
            2: count_value = 7'(TABLE_DEPTH);
            3: count_value = COUNT_WIDTH'($urandom_range(TABLE_DEPTH + 1, 127));
            4: count_value = '1;
            default: count_value = COUNT_WIDTH'($urandom_range(2, TABLE_DEPTH - 1));
         endcase
         if (phase == 0)
            count_value = '1;
         write_count(count_value);
         fill_count = (phase == 0 || $urandom_range(0, 5) == 0) ? TABLE_DEPTH
                                                                 : $urandom_range(1, 12);
         for (i = 0; i < fill_count; i++) begin
            issue(write_item((fill_count == TABLE_DEPTH) ? i
                                                         : $urandom_range(0, TABLE_DEPTH - 1),
                             random_extent(tame)));
            sender_gap(burst);
         end
         translate_count = $urandom_range(15, 50);
         for (i = 0; i < translate_count; i++) begin
            if ($urandom_range(0, 9) == 0)
               issue(write_item($urandom_range(0, TABLE_DEPTH - 1), random_extent(tame)));
            else
               issue(translate_item(pick_sector()));
            if ($urandom_range(0, 39) == 0)
               settle();
            else
               sender_gap(burst);
         end
         phase++;
      end
      settle();

      if (tracker.errors == 0 && tracker.pending_answers.size() == 0) begin
         $display("PASS extent_map_sector_translate");
      end else begin
         $display("FAIL extent_map_sector_translate");
      end
      $finish;
   end

endmodule

[files.f]
hw/rtl/emst_pkg.sv
hw/rtl/emst_ram.sv
hw/rtl/extent_map_sector_translate.sv
tb/sv/extent_translate_check_pkg.sv
tb/sv/tb_extent_map_sector_translate.sv
